FILE: hdl/ogu_pkg.sv
package ogu_pkg;

   localparam int ACC_W = 34;
   localparam int STEP_W = 24;
   localparam int LON_W = 32;
   localparam int LAT_W = 31;
   localparam int RANGE_W = 16;
   localparam int SEL_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_LON = 3'd0,
      CSR_ORIGIN_LAT = 3'd1,
      CSR_STEP_LON   = 3'd2,
      CSR_STEP_LAT   = 3'd3,
      CSR_THRESHOLD  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic checked;
      logic safe;
   } cell_flags_type;

   localparam cell_flags_type CELL_CLEARED = '{checked: 1'b0, safe: 1'b1};

   localparam logic signed [LON_W-1:0] ORIGIN_LON_RESET = 32'sd43767480;
   localparam logic signed [LAT_W-1:0] ORIGIN_LAT_RESET = 31'sd519906010;
   localparam logic [STEP_W-1:0] STEP_LON_RESET = 24'd69;
   localparam logic [STEP_W-1:0] STEP_LAT_RESET = 24'd40;
   localparam logic signed [RANGE_W-1:0] THRESHOLD_RESET = 16'sd1000;

endpackage

FILE: hdl/ogu_req_if.sv
interface ogu_req_if;
   logic valid;
   logic ready;
   logic [1:0] operation;
   logic signed [31:0] pos_lon;
   logic signed [30:0] pos_lat;
   logic signed [15:0] range_mm;
   logic [3:0] read_col;
   logic [3:0] read_row;

   modport source (
      output valid, operation, pos_lon, pos_lat, range_mm, read_col, read_row,
      input ready
   );
   modport sink (
      input valid, operation, pos_lon, pos_lat, range_mm, read_col, read_row,
      output ready
   );
endinterface

FILE: hdl/ogu_rsp_if.sv
interface ogu_rsp_if;
   logic valid;
   logic ready;
   logic [3:0] cell_col;
   logic [3:0] cell_row;
   logic cell_checked;
   logic cell_safe;

   modport source (
      output valid, cell_col, cell_row, cell_checked, cell_safe,
      input ready
   );
   modport sink (
      input valid, cell_col, cell_row, cell_checked, cell_safe,
      output ready
   );
endinterface

FILE: hdl/ogu_scan.sv
module ogu_scan #(
   parameter int IDX_W = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [ogu_pkg::ACC_W-1:0] coord,
   input  logic signed [ogu_pkg::ACC_W-1:0] origin,
   input  logic [ogu_pkg::STEP_W-1:0] step,
   input  logic [IDX_W-1:0] limit,
   output logic busy,
   output logic done,
   output logic [IDX_W-1:0] idx
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic signed [ogu_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [ogu_pkg::ACC_W-1:0] coord_ff, coord_in;
   logic signed [ogu_pkg::ACC_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] limit_ff, limit_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // Each cycle compares one cell boundary with the coordinate and steps to the next.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in = acc_ff;
      coord_in = coord_ff;
      step_in = step_ff;
      limit_in = limit_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in = origin;
         coord_in = coord;
         step_in = ogu_pkg::ACC_W'(step);
         limit_in = limit;
         count_in = '0;
         idx_in = '0;
      end else if (busy_ff) begin
         if (acc_ff > coord_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = count_ff;
            if (count_ff == limit_ff) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               acc_in = acc_ff + step_ff;
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      coord_ff <= coord_in;
      step_ff <= step_in;
      limit_ff <= limit_in;
      count_ff <= count_in;
      idx_ff <= idx_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign idx = idx_ff;

endmodule

FILE: hdl/ogu_grid_mem.sv
module ogu_grid_mem #(
   parameter int DEPTH = 196,
   parameter int ADDR_W = 8
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  ogu_pkg::cell_flags_type wr_data,
   input  logic rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output ogu_pkg::cell_flags_type rd_data
);

   ogu_pkg::cell_flags_type mem [DEPTH];
   ogu_pkg::cell_flags_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/occupancy_grid_update.sv
// Occupancy grid of GRID_COLS by GRID_ROWS cells, each holding a checked and a safe flag.
// An update word places its position into a cell by scanning the cell boundaries of one
// axis after the other on a single shared add-and-compare unit, one boundary per cycle,
// then reads, modifies and writes that cell in the grid memory. An update finishes sooner when
// the position lies near the grid origin; a read passes through a read step to the finish step;
// a clear sweeps the memory one cell per cycle; any other operation goes straight to the finish
// step. After reset the same sweep runs over every cell before the first word is accepted;
// register writes are taken at any time. One word is in work at a time, and the next one is
// accepted while the previous result still waits in the output register.
module occupancy_grid_update #(
   parameter int GRID_COLS = 14,
   parameter int GRID_ROWS = 14
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [ogu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ogu_pkg::CSR_DATA_W-1:0] csr_wdata,
   ogu_req_if.sink req_chan,
   ogu_rsp_if.source rsp_chan
);

   localparam int GRID_MAX = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
   localparam int IDX_W = $clog2(GRID_MAX);
   localparam int CELLS = GRID_COLS * GRID_ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LON    = 6'b000100,
      ST_LAT    = 6'b001000,
      ST_READ   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   ogu_pkg::op_type op_ff, op_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic signed [ogu_pkg::LAT_W-1:0] pos_lat_ff, pos_lat_in;
   logic signed [ogu_pkg::RANGE_W-1:0] range_ff, range_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] row_ff, row_in;

   logic signed [ogu_pkg::LON_W-1:0] origin_lon_ff;
   logic signed [ogu_pkg::LAT_W-1:0] origin_lat_ff;
   logic [ogu_pkg::STEP_W-1:0] step_lon_ff;
   logic [ogu_pkg::STEP_W-1:0] step_lat_ff;
   logic signed [ogu_pkg::RANGE_W-1:0] threshold_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_col_ff, rsp_col_in;
   logic [3:0] rsp_row_ff, rsp_row_in;
   logic rsp_chk_ff, rsp_chk_in;
   logic rsp_safe_ff, rsp_safe_in;

   logic accept;
   logic out_free;
   logic finish;
   logic scan_start;
   logic scan_busy;
   logic scan_done;
   logic [IDX_W-1:0] scan_idx;
   logic signed [ogu_pkg::ACC_W-1:0] scan_coord;
   logic signed [ogu_pkg::ACC_W-1:0] scan_origin;
   logic [ogu_pkg::STEP_W-1:0] scan_step;
   logic [IDX_W-1:0] scan_limit;

   logic mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   ogu_pkg::cell_flags_type mem_wr_data;
   logic mem_rd_en;
   logic [ADDR_W-1:0] cell_addr;
   ogu_pkg::cell_flags_type mem_rd_data;
   ogu_pkg::cell_flags_type upd_flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_lon_ff <= ogu_pkg::ORIGIN_LON_RESET;
         origin_lat_ff <= ogu_pkg::ORIGIN_LAT_RESET;
         step_lon_ff <= ogu_pkg::STEP_LON_RESET;
         step_lat_ff <= ogu_pkg::STEP_LAT_RESET;
         threshold_ff <= ogu_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ogu_pkg::CSR_ORIGIN_LON: origin_lon_ff <= csr_wdata[ogu_pkg::LON_W-1:0];
            ogu_pkg::CSR_ORIGIN_LAT: origin_lat_ff <= csr_wdata[ogu_pkg::LAT_W-1:0];
            ogu_pkg::CSR_STEP_LON: step_lon_ff <= csr_wdata[ogu_pkg::STEP_W-1:0];
            ogu_pkg::CSR_STEP_LAT: step_lat_ff <= csr_wdata[ogu_pkg::STEP_W-1:0];
            ogu_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata[ogu_pkg::RANGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign finish = (state_ff == ST_FINISH) && out_free;

   assign scan_start = (accept && (ogu_pkg::op_type'(req_chan.operation) == ogu_pkg::OP_UPDATE))
                       || ((state_ff == ST_LON) && scan_done);
   assign scan_coord = (state_ff == ST_IDLE) ? ogu_pkg::ACC_W'(req_chan.pos_lon)
                                             : ogu_pkg::ACC_W'(pos_lat_ff);
   assign scan_origin = (state_ff == ST_IDLE) ? ogu_pkg::ACC_W'(origin_lon_ff)
                                              : ogu_pkg::ACC_W'(origin_lat_ff);
   assign scan_step = (state_ff == ST_IDLE) ? step_lon_ff : step_lat_ff;
   assign scan_limit = (state_ff == ST_IDLE) ? IDX_W'(GRID_COLS - 1) : IDX_W'(GRID_ROWS - 1);

   ogu_scan #(
      .IDX_W(IDX_W)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .start(scan_start),
      .coord(scan_coord),
      .origin(scan_origin),
      .step(scan_step),
      .limit(scan_limit),
      .busy(scan_busy),
      .done(scan_done),
      .idx(scan_idx)
   );

   assign cell_addr = ADDR_W'(32'(col_ff) * GRID_ROWS + 32'(row_ff));
   assign upd_flags = '{checked: 1'b1, safe: mem_rd_data.safe && !(range_ff > threshold_ff)};

   always_comb begin
      mem_wr_en = 1'b0;
      mem_wr_addr = cell_addr;
      mem_wr_data = upd_flags;
      mem_rd_en = (state_ff == ST_READ);
      if (state_ff == ST_CLEAR) begin
         mem_wr_en = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = ogu_pkg::CELL_CLEARED;
      end else if (finish && (op_ff == ogu_pkg::OP_UPDATE)) begin
         mem_wr_en = 1'b1;
      end
   end

   ogu_grid_mem #(
      .DEPTH(CELLS),
      .ADDR_W(ADDR_W)
   ) u_grid_mem (
      .clock(clock),
      .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en(mem_rd_en),
      .rd_addr(cell_addr),
      .rd_data(mem_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      clr_addr_in = clr_addr_ff;
      pos_lat_in = pos_lat_ff;
      range_in = range_ff;
      col_in = col_ff;
      row_in = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_col_in = rsp_col_ff;
      rsp_row_in = rsp_row_ff;
      rsp_chk_in = rsp_chk_ff;
      rsp_safe_in = rsp_safe_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = (op_ff == ogu_pkg::OP_CLEAR) ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in = ogu_pkg::op_type'(req_chan.operation);
               pos_lat_in = req_chan.pos_lat;
               range_in = req_chan.range_mm;
               col_in = (32'(req_chan.read_col) >= GRID_COLS) ? IDX_W'(GRID_COLS - 1)
                                                               : IDX_W'(req_chan.read_col);
               row_in = (32'(req_chan.read_row) >= GRID_ROWS) ? IDX_W'(GRID_ROWS - 1)
                                                               : IDX_W'(req_chan.read_row);
               clr_addr_in = '0;
               unique case (ogu_pkg::op_type'(req_chan.operation))
                  ogu_pkg::OP_UPDATE: state_in = ST_LON;
                  ogu_pkg::OP_READ: state_in = ST_READ;
                  ogu_pkg::OP_CLEAR: state_in = ST_CLEAR;
                  ogu_pkg::OP_NOP: state_in = ST_FINISH;
               endcase
            end
         end
         ST_LON: begin
            if (scan_done) begin
               col_in = scan_idx;
               state_in = ST_LAT;
            end
         end
         ST_LAT: begin
            if (scan_done) begin
               row_in = scan_idx;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
               unique case (op_ff)
                  ogu_pkg::OP_UPDATE: begin
                     rsp_col_in = 4'(col_ff);
                     rsp_row_in = 4'(row_ff);
                     rsp_chk_in = upd_flags.checked;
                     rsp_safe_in = upd_flags.safe;
                  end
                  ogu_pkg::OP_READ: begin
                     rsp_col_in = 4'(col_ff);
                     rsp_row_in = 4'(row_ff);
                     rsp_chk_in = mem_rd_data.checked;
                     rsp_safe_in = mem_rd_data.safe;
                  end
                  ogu_pkg::OP_CLEAR: begin
                     rsp_col_in = '0;
                     rsp_row_in = '0;
                     rsp_chk_in = ogu_pkg::CELL_CLEARED.checked;
                     rsp_safe_in = ogu_pkg::CELL_CLEARED.safe;
                  end
                  ogu_pkg::OP_NOP: begin
                     rsp_col_in = '0;
                     rsp_row_in = '0;
                     rsp_chk_in = 1'b0;
                     rsp_safe_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         op_ff <= ogu_pkg::OP_NOP;
         clr_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         clr_addr_ff <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_lat_ff <= pos_lat_in;
      range_ff <= range_in;
      col_ff <= col_in;
      row_ff <= row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_row_ff <= rsp_row_in;
      rsp_chk_ff <= rsp_chk_in;
      rsp_safe_ff <= rsp_safe_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.cell_col = rsp_col_ff;
   assign rsp_chan.cell_row = rsp_row_ff;
   assign rsp_chan.cell_checked = rsp_chk_ff;
   assign rsp_chan.cell_safe = rsp_safe_ff;

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result word raised outside the finish step");

   a_update_checked: assert property (@(posedge clock) disable iff (reset)
      (finish && (op_ff == ogu_pkg::OP_UPDATE)) |=> (rsp_valid_ff && rsp_chk_ff))
      else $error("updated cell not reported as checked");

   a_cell_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> ((32'(col_ff) < GRID_COLS) && (32'(row_ff) < GRID_ROWS)))
      else $error("cell index outside the grid");

   a_scan_in_axis_state: assert property (@(posedge clock) disable iff (reset)
      (scan_busy || scan_done) |-> ((state_ff == ST_LON) || (state_ff == ST_LAT)))
      else $error("boundary scan active outside an axis step");
`endif

endmodule

FILE: tb/sv/occupancy_grid_update_tb.sv
`timescale 1ns / 100ps

module occupancy_grid_update_tb;

   localparam int GRID_COLS = 14;
   localparam int GRID_ROWS = 14;
   localparam int RANDOM_WORDS = 480;
   localparam int RANDOM_PHASES = 5;
   localparam int LON_W = ogu_pkg::LON_W;
   localparam int LAT_W = ogu_pkg::LAT_W;
   localparam int RANGE_W = ogu_pkg::RANGE_W;
   localparam int STEP_W = ogu_pkg::STEP_W;
   localparam int SEL_W = ogu_pkg::SEL_W;
   localparam int CSR_INDEX_W = ogu_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W = ogu_pkg::CSR_DATA_W;

   typedef struct packed {
      ogu_pkg::op_type op;
      logic signed [LON_W-1:0] lon;
      logic signed [LAT_W-1:0] lat;
      logic signed [RANGE_W-1:0] range_mm;
      logic [SEL_W-1:0] col;
      logic [SEL_W-1:0] row;
   } grid_word_type;

   typedef struct packed {
      logic [SEL_W-1:0] col;
      logic [SEL_W-1:0] row;
      logic checked;
      logic safe;
   } cell_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ogu_req_if req_chan();
   ogu_rsp_if rsp_chan();

   occupancy_grid_update #(
      .GRID_COLS(GRID_COLS),
      .GRID_ROWS(GRID_ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   ogu_pkg::cell_flags_type grid_model [GRID_COLS][GRID_ROWS];
   logic signed [LON_W-1:0] origin_lon_cfg;
   logic signed [LAT_W-1:0] origin_lat_cfg;
   logic [STEP_W-1:0] step_lon_cfg;
   logic [STEP_W-1:0] step_lat_cfg;
   logic signed [RANGE_W-1:0] threshold_cfg;

   cell_report_type pending_cells[$];
   int errors = 0;
   int reports_checked = 0;
   int op_counts[4] = '{0, 0, 0, 0};
   bit steady = 1'b0;

   always #6 clock = ~clock;

   function automatic void clear_model();
      foreach (grid_model[c, r]) grid_model[c][r] = ogu_pkg::CELL_CLEARED;
   endfunction

   function automatic int cell_index(longint coord, longint origin, longint step, int count);
      longint idx;
      if (coord < origin) return 0;
      if (step == 0) return count - 1;
      idx = (coord - origin) / step;
      if (idx >= count) idx = count - 1;
      return int'(idx);
   endfunction

   function automatic cell_report_type grid_outcome(grid_word_type w);
      cell_report_type rep;
      int c;
      int r;
      rep = '0;
      case (w.op)
         ogu_pkg::OP_UPDATE: begin
            c = cell_index(w.lon, origin_lon_cfg, step_lon_cfg, GRID_COLS);
            r = cell_index(w.lat, origin_lat_cfg, step_lat_cfg, GRID_ROWS);
            grid_model[c][r].checked = 1'b1;
            if (w.range_mm > threshold_cfg) grid_model[c][r].safe = 1'b0;
            rep = '{col: SEL_W'(c), row: SEL_W'(r), checked: grid_model[c][r].checked,
                    safe: grid_model[c][r].safe};
         end
         ogu_pkg::OP_READ: begin
            c = (w.col >= GRID_COLS) ? GRID_COLS - 1 : int'(w.col);
            r = (w.row >= GRID_ROWS) ? GRID_ROWS - 1 : int'(w.row);
            rep = '{col: SEL_W'(c), row: SEL_W'(r), checked: grid_model[c][r].checked,
                    safe: grid_model[c][r].safe};
         end
         ogu_pkg::OP_CLEAR: begin
            clear_model();
            rep.safe = 1'b1;
         end
         default: ;
      endcase
      return rep;
   endfunction

   function automatic longint clamp_signed(longint v, int width);
      longint lo;
      longint hi;
      lo = -(longint'(1) << (width - 1));
      hi = (longint'(1) << (width - 1)) - 1;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Positions land on or next to a cell boundary, or inside a cell, from one cell below the
   // grid to two cells beyond it.
   function automatic longint near_coord(longint origin, longint step, int width);
      longint v;
      v = origin + (longint'($urandom_range(0, GRID_COLS + 2)) - 1) * step;
      case ($urandom_range(3))
         0: v = v - 1;
         1: v = v + 1;
         2: v = v + longint'($urandom_range(0, int'(step)));
         default: ;
      endcase
      return clamp_signed(v, width);
   endfunction

   function automatic grid_word_type make_word(ogu_pkg::op_type op, longint lon, longint lat,
                                               longint range_mm, int col, int row);
      grid_word_type w;
      w.op = op;
      w.lon = LON_W'(lon);
      w.lat = LAT_W'(lat);
      w.range_mm = RANGE_W'(range_mm);
      w.col = SEL_W'(col);
      w.row = SEL_W'(row);
      return w;
   endfunction

   function automatic grid_word_type random_word();
      grid_word_type w;
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) w.op = ogu_pkg::OP_UPDATE;
      else if (pick < 87) w.op = ogu_pkg::OP_READ;
      else if (pick < 93) w.op = ogu_pkg::OP_CLEAR;
      else w.op = ogu_pkg::OP_NOP;
      w.lon = ($urandom_range(99) < 85) ? LON_W'(near_coord(origin_lon_cfg, step_lon_cfg, LON_W))
                                        : LON_W'($urandom);
      w.lat = ($urandom_range(99) < 85) ? LAT_W'(near_coord(origin_lat_cfg, step_lat_cfg, LAT_W))
                                        : LAT_W'($urandom);
      if ($urandom_range(1) == 0)
         w.range_mm = RANGE_W'(clamp_signed(longint'(threshold_cfg) +
                                            longint'($urandom_range(0, 4)) - 2, RANGE_W));
      else
         w.range_mm = RANGE_W'($urandom);
      w.col = SEL_W'($urandom_range(15));
      w.row = SEL_W'($urandom_range(15));
      return w;
   endfunction

   task automatic send_word(grid_word_type w);
      if (!steady && $urandom_range(99) < 25) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 32 : 3)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= w.op;
      req_chan.pos_lon <= w.lon;
      req_chan.pos_lat <= w.lat;
      req_chan.range_mm <= w.range_mm;
      req_chan.read_col <= w.col;
      req_chan.read_row <= w.row;
      do @(posedge clock); while (!req_chan.ready);
      pending_cells.push_back(grid_outcome(w));
      op_counts[int'(w.op)]++;
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_cells.size() != 0);
   endtask

   task automatic csr_write(ogu_pkg::csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         ogu_pkg::CSR_ORIGIN_LON: origin_lon_cfg = value[LON_W-1:0];
         ogu_pkg::CSR_ORIGIN_LAT: origin_lat_cfg = value[LAT_W-1:0];
         ogu_pkg::CSR_STEP_LON: step_lon_cfg = value[STEP_W-1:0];
         ogu_pkg::CSR_STEP_LAT: step_lat_cfg = value[STEP_W-1:0];
         ogu_pkg::CSR_THRESHOLD: threshold_cfg = value[RANGE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [31:0] lon, logic [31:0] lat, logic [31:0] slon,
                                 logic [31:0] slat, logic [31:0] thr);
      csr_write(ogu_pkg::CSR_ORIGIN_LON, lon);
      csr_write(ogu_pkg::CSR_ORIGIN_LAT, lat);
      csr_write(ogu_pkg::CSR_STEP_LON, slon);
      csr_write(ogu_pkg::CSR_STEP_LAT, slat);
      csr_write(ogu_pkg::CSR_THRESHOLD, thr);
      csr_we <= 1'b0;
   endtask

   task automatic test_directed_cases();
      longint lon0;
      longint lat0;
      lon0 = origin_lon_cfg;
      lat0 = origin_lat_cfg;
      send_word(make_word(ogu_pkg::OP_UPDATE, lon0, lat0, 1000, 0, 0));
      send_word(make_word(ogu_pkg::OP_UPDATE, lon0 - 1, lat0 - 1, 1001, 15, 15));
      send_word(make_word(ogu_pkg::OP_UPDATE, lon0 + 13 * 69, lat0 + 13 * 40, 999, 0, 0));
      send_word(make_word(ogu_pkg::OP_UPDATE, lon0 + 13 * 69 - 1, lat0 + 13 * 40 - 1,
                          -1, 0, 0));
      send_word(make_word(ogu_pkg::OP_UPDATE, 2147483647, 1073741823, 32767, 0, 0));
      send_word(make_word(ogu_pkg::OP_UPDATE, -2147483647 - 1, -1073741824, -32768, 0, 0));
      send_word(make_word(ogu_pkg::OP_UPDATE, 1800000000, 900000000, 0, 0, 0));
      send_word(make_word(ogu_pkg::OP_UPDATE, -1800000000, -900000000, 32767, 0, 0));
      send_word(make_word(ogu_pkg::OP_UPDATE, lon0 + 5 * 69 + 10, lat0 + 7 * 40 + 39,
                          1000, 0, 0));
      send_word(make_word(ogu_pkg::OP_READ, 0, 0, 0, 0, 0));
      send_word(make_word(ogu_pkg::OP_READ, 0, 0, 0, 13, 13));
      send_word(make_word(ogu_pkg::OP_READ, 0, 0, 0, 15, 15));
      send_word(make_word(ogu_pkg::OP_READ, 0, 0, 0, 14, 3));
      send_word(make_word(ogu_pkg::OP_READ, 0, 0, 0, 5, 7));
      send_word(make_word(ogu_pkg::OP_READ, 0, 0, 0, 12, 12));
      send_word(make_word(ogu_pkg::OP_NOP, -1, -1, -1, 15, 15));
      send_word(make_word(ogu_pkg::OP_CLEAR, -1, -1, -1, 15, 15));
      send_word(make_word(ogu_pkg::OP_READ, 0, 0, 0, 0, 0));
      send_word(make_word(ogu_pkg::OP_READ, 0, 0, 0, 13, 13));
   endtask

   task automatic test_register_extremes();
      for (int phase = 0; phase < 5; phase++) begin
         wait_for_results();
         case (phase)
            0: apply_settings(-1800000000, -900000000, 32'h00FFFFFF, 32'h00FFFFFF, -32768);
            1: apply_settings(1800000000, 900000000, 1, 1, 32767);
            2: apply_settings($urandom, $urandom, 0, 0, 0);
            3: apply_settings(32'h7FFFFFFF, 32'h3FFFFFFF, 1, 0, -1);
            default: apply_settings(32'h80000000, 32'h40000000, 0, 32'h00FFFFFF, 1000);
         endcase
         repeat (25) send_word(random_word());
      end
   endtask

   task automatic test_sender_pause();
      steady = 1'b1;
      repeat (20) send_word(random_word());
      steady = 1'b0;
      wait_for_results();
      repeat (10) send_word(random_word());
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         if (phase == 0)
            apply_settings(32'(ogu_pkg::ORIGIN_LON_RESET), 32'(ogu_pkg::ORIGIN_LAT_RESET),
                           32'(ogu_pkg::STEP_LON_RESET), 32'(ogu_pkg::STEP_LAT_RESET),
                           32'(ogu_pkg::THRESHOLD_RESET));
         else
            apply_settings($urandom, $urandom,
                           ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 400),
                           ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 400),
                           $urandom);
         steady = (phase == 2);
         repeat (RANDOM_WORDS / RANDOM_PHASES) send_word(random_word());
         steady = 1'b0;
      end
   endtask

   task automatic report_field(string name, logic [SEL_W-1:0] want, logic [SEL_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      cell_report_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_cells.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected word, expected none, actual col %0d row %0d", $time,
                     rsp_chan.cell_col, rsp_chan.cell_row);
         end else begin
            want = pending_cells.pop_front();
            reports_checked++;
            report_field("cell_col", want.col, rsp_chan.cell_col);
            report_field("cell_row", want.row, rsp_chan.cell_row);
            report_field("cell_checked", SEL_W'(want.checked), SEL_W'(rsp_chan.cell_checked));
            report_field("cell_safe", SEL_W'(want.safe), SEL_W'(rsp_chan.cell_safe));
         end
      end
   end

   always @(posedge clock) rsp_chan.ready <= steady || ($urandom_range(99) >= 25);

   initial begin
      req_chan.valid = 1'b0;
      req_chan.operation = ogu_pkg::OP_NOP;
      req_chan.pos_lon = '0;
      req_chan.pos_lat = '0;
      req_chan.range_mm = '0;
      req_chan.read_col = '0;
      req_chan.read_row = '0;
      csr_we = 1'b0;
      csr_index = ogu_pkg::CSR_ORIGIN_LON;
      csr_wdata = '0;
      origin_lon_cfg = ogu_pkg::ORIGIN_LON_RESET;
      origin_lat_cfg = ogu_pkg::ORIGIN_LAT_RESET;
      step_lon_cfg = ogu_pkg::STEP_LON_RESET;
      step_lat_cfg = ogu_pkg::STEP_LAT_RESET;
      threshold_cfg = ogu_pkg::THRESHOLD_RESET;
      clear_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_register_extremes();
      test_sender_pause();
      test_random_traffic();

      wait_for_results();
      repeat (40) @(posedge clock);
      $display("Checked %0d result words: %0d updates, %0d reads, %0d clears, %0d ignored.",
               reports_checked, op_counts[ogu_pkg::OP_UPDATE], op_counts[ogu_pkg::OP_READ],
               op_counts[ogu_pkg::OP_CLEAR], op_counts[ogu_pkg::OP_NOP]);
      $display("Settings covered reset values, origin and step extremes, and zero steps.");
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #12000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
